/* hw/rtl/fsfe_pkg.sv */
// Shared types, command codes and fixed-point helpers for the shape-function evaluator.
// No dependencies; used by fsfe_div and fem_shape_function_eval_core.
package fsfe_pkg;

    // Command codes on s_cmd
    typedef enum logic [2:0] {
        CMD_WR_NODE  = 3'd0,
        CMD_WR_LINE  = 3'd1,
        CMD_WR_MASK  = 3'd2,
        CMD_WR_COUNT = 3'd3,
        CMD_EVAL     = 3'd4
    } cmd_t;

    // Divider operand widths: dividend 2|n|+|d| < 2^52, divisor 2|d| < 2^36
    localparam int DIV_NW = 52;
    localparam int DIV_DW = 36;

    // Factor lanes per node (mask is 8 bits wide)
    localparam int LANES = 8;
    localparam logic signed [31:0] Q_ONE = 32'sd65536;

    typedef struct packed {
        logic              start;
        logic              neg;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] result;
    } div_rsp_t;

    // Apply sign to a magnitude and saturate to signed 32 bits
    function automatic logic signed [31:0] sat_q(input logic neg, input logic [63:0] q);
        logic signed [31:0] r;
        if (neg) begin
            if (q > 64'h8000_0000) r = 32'sh8000_0000;
            else r = 32'(64'd0 - q);
        end else begin
            if (q > 64'h7fff_ffff) r = 32'sh7fff_ffff;
            else r = q[31:0];
        end
        return r;
    endfunction

    // Q16.16 product rescale: round half away from zero, saturate
    function automatic logic signed [31:0] q_round(input logic signed [63:0] p);
        logic [63:0] mag;
        logic [63:0] q;
        mag = p[63] ? 64'(-p) : 64'(p);
        q   = (mag + 64'd32768) >> 16;
        return sat_q(p[63], q);
    endfunction

    // Saturate an accumulated derivative sum
    function automatic logic signed [31:0] sat_sum(input logic signed [34:0] s);
        logic signed [31:0] r;
        if (s > 35'sd2147483647) r = 32'sh7fff_ffff;
        else if (s < -35'sd2147483648) r = 32'sh8000_0000;
        else r = s[31:0];
        return r;
    endfunction

endpackage

/* hw/rtl/fem_shape_function_eval_core.sv */
// Shape-function evaluator top level: table RAMs, sequencer, shared multiplier.
// Depends on fsfe_pkg, fsfe_ram and fsfe_div.
//
// Usage: commands arrive on the s_ channel (valid/ready). Write commands
// (node, line, mask, counts) update the shape tables and give no result.
// An evaluate command produces one m_ transaction per node of the selected
// shape, in node order, with m_last set on the final node; a shape with zero
// nodes or an out-of-range shape id gives nothing.
// Throughput: one command at a time; s_ready is high only while idle.
// Per node, an evaluation reads the node and scans its lines: for each masked
// line it reads the end points, forms the line terms and takes three quotients
// (factor, x and y gradient) in the bit-serial divider. Unless the node is
// degenerate, a second scan uses the shared 32x32 multiplier per masked line
// for the value product, the product of the other factors and both gradient
// terms. The divider dominates. First result appears after one node's work.
// Stall: results sit in an output register; while the receiver stalls
// the sequencer holds at the next result. The output register lets the
// next command be accepted while the last result waits.
// Reset: synchronous, active low; node and line counts clear to zero,
// the coordinate, line and mask tables are undefined until written.
module fem_shape_function_eval_core #(
    parameter int NUM_SHAPES = 8,
    parameter int MAX_NODES  = 16,
    parameter int MAX_LINES  = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_cmd,
    input  logic [2:0]         s_shape_id,
    input  logic [3:0]         s_index,
    input  logic signed [15:0] s_node_x,
    input  logic signed [15:0] s_node_y,
    input  logic [3:0]         s_line_first,
    input  logic [3:0]         s_line_second,
    input  logic [7:0]         s_line_mask,
    input  logic [4:0]         s_node_total,
    input  logic [3:0]         s_line_total,
    input  logic signed [15:0] s_point_x,
    input  logic signed [15:0] s_point_y,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_node_number,
    output logic signed [31:0] m_value,
    output logic signed [31:0] m_deriv_x,
    output logic signed [31:0] m_deriv_y,
    output logic               m_degenerate,
    output logic               m_last
);

    localparam int NDEPTH = NUM_SHAPES * MAX_NODES;
    localparam int LDEPTH = NUM_SHAPES * MAX_LINES;
    localparam int NAW    = (NDEPTH > 1) ? $clog2(NDEPTH) : 1;
    localparam int LAW    = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
    localparam int SW     = (NUM_SHAPES > 1) ? $clog2(NUM_SHAPES) : 1;

    typedef enum logic [14:0] {
        ST_IDLE     = 15'h0001,
        ST_NODE_RD  = 15'h0002,
        ST_NODE_WT  = 15'h0004,
        ST_LINE_CHK = 15'h0008,
        ST_LINE_WT  = 15'h0010,
        ST_A_WT     = 15'h0020,
        ST_B_WT     = 15'h0040,
        ST_CALC_D   = 15'h0080,
        ST_CALC_N   = 15'h0100,
        ST_DIV      = 15'h0200,
        ST_B_CHK    = 15'h0400,
        ST_MUL      = 15'h0800,
        ST_MUL_WB   = 15'h1000,
        ST_K_CHK    = 15'h2000,
        ST_EMIT     = 15'h4000
    } state_t;

    typedef enum logic [1:0] {
        OP_VAL = 2'd0,
        OP_DP  = 2'd1,
        OP_GX  = 2'd2,
        OP_GY  = 2'd3
    } mul_op_t;

    typedef enum logic [1:0] {
        DV_F  = 2'd0,
        DV_GX = 2'd1,
        DV_GY = 2'd2
    } div_op_t;

    state_t  state_reg;
    mul_op_t mul_op_reg;
    div_op_t div_op_reg;
    logic    div_start_reg;
    logic    m_valid_reg;

    logic [4:0] node_cnt_reg [NUM_SHAPES];
    logic [3:0] line_cnt_reg [NUM_SHAPES];

    logic [SW-1:0]      sid_reg;
    logic [4:0]         nn_reg;
    logic [3:0]         nl_reg;
    logic [3:0]         n_reg;
    logic [3:0]         l_reg;
    logic [3:0]         k_reg;
    logic signed [15:0] px_reg, py_reg;
    logic signed [15:0] nx_reg, ny_reg;
    logic [7:0]         mask_reg;
    logic [3:0]         b_idx_reg;
    logic               a_oob_reg, b_oob_reg;
    logic signed [15:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [34:0] d_reg, num_reg;
    logic               degen_reg;
    logic signed [31:0] val_reg, dp_reg;
    logic signed [34:0] sdx_reg, sdy_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] f_reg  [fsfe_pkg::LANES];
    logic signed [31:0] gx_reg [fsfe_pkg::LANES];
    logic signed [31:0] gy_reg [fsfe_pkg::LANES];

    logic [3:0]         o_node_reg;
    logic signed [31:0] o_val_reg, o_dx_reg, o_dy_reg;
    logic               o_degen_reg, o_last_reg;

    // ---------------------------------------------------------------
    // input decode
    logic          s_acc;
    logic          sid_ok;
    logic [SW-1:0] s_sid;
    logic [4:0]    nn_clamp;
    logic [3:0]    nl_clamp;
    logic [4:0]    cnt_node;
    logic [3:0]    cnt_line;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_acc    = s_valid && s_ready;
    assign sid_ok   = 32'(s_shape_id) < NUM_SHAPES;
    assign s_sid    = SW'(s_shape_id);
    assign cnt_node = node_cnt_reg[s_sid];
    assign cnt_line = line_cnt_reg[s_sid];
    assign nn_clamp = (cnt_node > 5'd16) ? 5'd16 : cnt_node;
    assign nl_clamp = (cnt_line > 4'd8) ? 4'd8 : cnt_line;

    // table writes
    logic           coord_we, mask_we, line_we;
    logic [NAW-1:0] wr_naddr;
    logic [LAW-1:0] wr_laddr;

    assign wr_naddr = NAW'(32'(s_shape_id) * MAX_NODES + 32'(s_index));
    assign wr_laddr = LAW'(32'(s_shape_id) * MAX_LINES + 32'(s_index));
    assign coord_we = s_acc && sid_ok && (s_cmd == fsfe_pkg::CMD_WR_NODE)
                      && (32'(s_index) < MAX_NODES);
    assign mask_we  = s_acc && sid_ok && (s_cmd == fsfe_pkg::CMD_WR_MASK)
                      && (32'(s_index) < MAX_NODES);
    assign line_we  = s_acc && sid_ok && (s_cmd == fsfe_pkg::CMD_WR_LINE)
                      && (32'(s_index) < MAX_LINES);

    // ---------------------------------------------------------------
    // table RAMs
    logic [NAW-1:0] coord_raddr, node_raddr;
    logic [LAW-1:0] line_raddr;
    logic [31:0]    coord_rdata;
    logic [7:0]     mask_rdata;
    logic [7:0]     line_rdata;

    assign node_raddr = NAW'(32'(sid_reg) * MAX_NODES + 32'(n_reg));
    assign line_raddr = LAW'(32'(sid_reg) * MAX_LINES + 32'(l_reg));

    // coordinate read address follows the sequencer
    always_comb begin
        case (state_reg)
            ST_LINE_WT: coord_raddr = NAW'(32'(sid_reg) * MAX_NODES + 32'(line_rdata[7:4]));
            ST_A_WT:    coord_raddr = NAW'(32'(sid_reg) * MAX_NODES + 32'(b_idx_reg));
            default:    coord_raddr = node_raddr;
        endcase
    end

    fsfe_ram #(.WIDTH(32), .DEPTH(NDEPTH)) u_coord_ram (
        .clk   (aclk),
        .we    (coord_we),
        .waddr (wr_naddr),
        .wdata ({s_node_x, s_node_y}),
        .raddr (coord_raddr),
        .rdata (coord_rdata)
    );

    fsfe_ram #(.WIDTH(8), .DEPTH(NDEPTH)) u_mask_ram (
        .clk   (aclk),
        .we    (mask_we),
        .waddr (wr_naddr),
        .wdata (s_line_mask),
        .raddr (node_raddr),
        .rdata (mask_rdata)
    );

    fsfe_ram #(.WIDTH(8), .DEPTH(LDEPTH)) u_line_ram (
        .clk   (aclk),
        .we    (line_we),
        .waddr (wr_laddr),
        .wdata ({s_line_first, s_line_second}),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    // ---------------------------------------------------------------
    // line equation terms
    logic signed [16:0] dx, dy, rnx, rny, rpx, rpy;
    logic signed [33:0] t1, t2, t3, t4;
    logic [34:0]        d_mag, num_mag;
    logic [15:0]        dx_mag, dy_mag;

    assign dx  = 17'(bx_reg) - 17'(ax_reg);
    assign dy  = 17'(by_reg) - 17'(ay_reg);
    assign rny = 17'(ny_reg) - 17'(ay_reg);
    assign rnx = 17'(nx_reg) - 17'(ax_reg);
    assign rpy = 17'(py_reg) - 17'(ay_reg);
    assign rpx = 17'(px_reg) - 17'(ax_reg);
    assign t1  = dx * rny;
    assign t2  = dy * rnx;
    assign t3  = dx * rpy;
    assign t4  = dy * rpx;

    assign d_mag   = d_reg[34] ? 35'(-d_reg) : 35'(d_reg);
    assign num_mag = num_reg[34] ? 35'(-num_reg) : 35'(num_reg);
    assign dx_mag  = dx[16] ? 16'(-dx) : 16'(dx);
    assign dy_mag  = dy[16] ? 16'(-dy) : 16'(dy);

    // divider request: rounded quotient as (2|n| + |d|) / (2|d|)
    fsfe_pkg::div_req_t div_req;
    fsfe_pkg::div_rsp_t div_rsp;

    always_comb begin
        div_req.start = div_start_reg;
        div_req.den   = {d_mag, 1'b0};
        case (div_op_reg)
            DV_F: begin
                div_req.num = {num_mag, 17'b0} + 52'(d_mag);
                div_req.neg = num_reg[34] != d_reg[34];
            end
            DV_GX: begin
                div_req.num = 52'({dy_mag, 29'b0}) + 52'(d_mag);
                div_req.neg = (dy > 17'sd0) != d_reg[34];
            end
            default: begin
                div_req.num = 52'({dx_mag, 29'b0}) + 52'(d_mag);
                div_req.neg = dx[16] != d_reg[34];
            end
        endcase
    end

    fsfe_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // ---------------------------------------------------------------
    // shared multiplier operands
    logic signed [31:0] mul_a, mul_b, mul_r;

    always_comb begin
        case (mul_op_reg)
            OP_VAL: begin
                mul_a = val_reg;
                mul_b = f_reg[l_reg[2:0]];
            end
            OP_DP: begin
                mul_a = dp_reg;
                mul_b = f_reg[k_reg[2:0]];
            end
            OP_GX: begin
                mul_a = dp_reg;
                mul_b = gx_reg[l_reg[2:0]];
            end
            default: begin
                mul_a = dp_reg;
                mul_b = gy_reg[l_reg[2:0]];
            end
        endcase
    end

    assign mul_r = fsfe_pkg::q_round(prod_reg);

    logic l_end, k_end, n_last, out_free;
    assign l_end    = (l_reg == nl_reg);
    assign k_end    = (k_reg == nl_reg);
    assign n_last   = ({1'b0, n_reg} == (nn_reg - 5'd1));
    assign out_free = !m_valid_reg || m_ready;

    // ---------------------------------------------------------------
    // sequencer and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mul_op_reg    <= OP_VAL;
            div_op_reg    <= DV_F;
            div_start_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < NUM_SHAPES; i++) begin
                node_cnt_reg[i] <= '0;
                line_cnt_reg[i] <= '0;
            end
        end else begin
            div_start_reg <= 1'b0;
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_acc && sid_ok) begin
                        if (s_cmd == fsfe_pkg::CMD_WR_COUNT) begin
                            node_cnt_reg[s_sid] <= (32'(s_node_total) > MAX_NODES)
                                                   ? 5'(MAX_NODES) : s_node_total;
                            line_cnt_reg[s_sid] <= (32'(s_line_total) > MAX_LINES)
                                                   ? 4'(MAX_LINES) : s_line_total;
                        end else if (s_cmd == fsfe_pkg::CMD_EVAL && nn_clamp != 5'd0) begin
                            state_reg <= ST_NODE_RD;
                        end
                    end
                end
                ST_NODE_RD:  state_reg <= ST_NODE_WT;
                ST_NODE_WT:  state_reg <= ST_LINE_CHK;
                ST_LINE_CHK: begin
                    if (l_end) begin
                        state_reg <= degen_reg ? ST_EMIT : ST_B_CHK;
                    end else if (mask_reg[l_reg[2:0]]) begin
                        state_reg <= ST_LINE_WT;
                    end
                end
                ST_LINE_WT: state_reg <= ST_A_WT;
                ST_A_WT:    state_reg <= ST_B_WT;
                ST_B_WT:    state_reg <= ST_CALC_D;
                ST_CALC_D:  state_reg <= ST_CALC_N;
                ST_CALC_N: begin
                    if (d_reg == '0) begin
                        state_reg <= ST_LINE_CHK;
                    end else begin
                        div_op_reg    <= DV_F;
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_rsp.done) begin
                        case (div_op_reg)
                            DV_F: begin
                                div_op_reg    <= DV_GX;
                                div_start_reg <= 1'b1;
                            end
                            DV_GX: begin
                                div_op_reg    <= DV_GY;
                                div_start_reg <= 1'b1;
                            end
                            default: state_reg <= ST_LINE_CHK;
                        endcase
                    end
                end
                ST_B_CHK: begin
                    if (l_end) begin
                        state_reg <= ST_EMIT;
                    end else if (mask_reg[l_reg[2:0]]) begin
                        mul_op_reg <= OP_VAL;
                        state_reg  <= ST_MUL;
                    end
                end
                ST_MUL: state_reg <= ST_MUL_WB;
                ST_MUL_WB: begin
                    case (mul_op_reg)
                        OP_VAL: state_reg <= ST_K_CHK;
                        OP_DP:  state_reg <= ST_K_CHK;
                        OP_GX: begin
                            mul_op_reg <= OP_GY;
                            state_reg  <= ST_MUL;
                        end
                        default: state_reg <= ST_B_CHK;
                    endcase
                end
                ST_K_CHK: begin
                    if (k_end) begin
                        mul_op_reg <= OP_GX;
                        state_reg  <= ST_MUL;
                    end else if (k_reg != l_reg && mask_reg[k_reg[2:0]]) begin
                        mul_op_reg <= OP_DP;
                        state_reg  <= ST_MUL;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= n_last ? ST_IDLE : ST_NODE_RD;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // datapath registers
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            ST_IDLE: begin
                sid_reg <= s_sid;
                nn_reg  <= nn_clamp;
                nl_reg  <= nl_clamp;
                px_reg  <= s_point_x;
                py_reg  <= s_point_y;
                n_reg   <= '0;
            end
            ST_NODE_WT: begin
                nx_reg    <= coord_rdata[31:16];
                ny_reg    <= coord_rdata[15:0];
                mask_reg  <= mask_rdata;
                degen_reg <= 1'b0;
                l_reg     <= '0;
            end
            ST_LINE_CHK: begin
                if (l_end) begin
                    l_reg   <= '0;
                    val_reg <= fsfe_pkg::Q_ONE;
                    sdx_reg <= '0;
                    sdy_reg <= '0;
                end else if (!mask_reg[l_reg[2:0]]) begin
                    l_reg <= l_reg + 4'd1;
                end
            end
            ST_LINE_WT: begin
                b_idx_reg <= line_rdata[3:0];
                a_oob_reg <= 32'(line_rdata[7:4]) >= MAX_NODES;
                b_oob_reg <= 32'(line_rdata[3:0]) >= MAX_NODES;
            end
            ST_A_WT: begin
                ax_reg <= a_oob_reg ? 16'sd0 : coord_rdata[31:16];
                ay_reg <= a_oob_reg ? 16'sd0 : coord_rdata[15:0];
            end
            ST_B_WT: begin
                bx_reg <= b_oob_reg ? 16'sd0 : coord_rdata[31:16];
                by_reg <= b_oob_reg ? 16'sd0 : coord_rdata[15:0];
            end
            ST_CALC_D: d_reg   <= 35'(t1) - 35'(t2);
            ST_CALC_N: begin
                num_reg <= 35'(t3) - 35'(t4);
                if (d_reg == '0) begin
                    degen_reg <= 1'b1;
                    l_reg     <= l_reg + 4'd1;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    case (div_op_reg)
                        DV_F:  f_reg[l_reg[2:0]]  <= div_rsp.result;
                        DV_GX: gx_reg[l_reg[2:0]] <= div_rsp.result;
                        default: begin
                            gy_reg[l_reg[2:0]] <= div_rsp.result;
                            l_reg              <= l_reg + 4'd1;
                        end
                    endcase
                end
            end
            ST_B_CHK: begin
                if (!l_end && !mask_reg[l_reg[2:0]]) begin
                    l_reg <= l_reg + 4'd1;
                end
            end
            ST_MUL_WB: begin
                case (mul_op_reg)
                    OP_VAL: begin
                        val_reg <= mul_r;
                        dp_reg  <= fsfe_pkg::Q_ONE;
                        k_reg   <= '0;
                    end
                    OP_DP: begin
                        dp_reg <= mul_r;
                        k_reg  <= k_reg + 4'd1;
                    end
                    OP_GX: sdx_reg <= sdx_reg + 35'(mul_r);
                    default: begin
                        sdy_reg <= sdy_reg + 35'(mul_r);
                        l_reg   <= l_reg + 4'd1;
                    end
                endcase
            end
            ST_K_CHK: begin
                if (!k_end && !(k_reg != l_reg && mask_reg[k_reg[2:0]])) begin
                    k_reg <= k_reg + 4'd1;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    o_node_reg  <= n_reg;
                    o_val_reg   <= degen_reg ? 32'sd0 : val_reg;
                    o_dx_reg    <= degen_reg ? 32'sd0 : fsfe_pkg::sat_sum(sdx_reg);
                    o_dy_reg    <= degen_reg ? 32'sd0 : fsfe_pkg::sat_sum(sdy_reg);
                    o_degen_reg <= degen_reg;
                    o_last_reg  <= n_last;
                    n_reg       <= n_reg + 4'd1;
                end
            end
            default: ;
        endcase
    end

    // result channel
    assign m_valid       = m_valid_reg;
    assign m_node_number = o_node_reg;
    assign m_value       = o_val_reg;
    assign m_deriv_x     = o_dx_reg;
    assign m_deriv_y     = o_dy_reg;
    assign m_degenerate  = o_degen_reg;
    assign m_last        = o_last_reg;

endmodule

/* hw/rtl/fsfe_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fsfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

/* hw/rtl/fsfe_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle, saturating signed result.
// Depends on fsfe_pkg.
module fsfe_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  fsfe_pkg::div_req_t req,
    output fsfe_pkg::div_rsp_t rsp
);

    localparam int NW = fsfe_pkg::DIV_NW;
    localparam int DW = fsfe_pkg::DIV_DW;
    localparam int CW = $clog2(NW);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] rem_reg;
    logic [NW-1:0] quo_reg;
    logic [DW-1:0] den_reg;
    logic          neg_reg;

    logic [DW:0] rem_sh;
    logic        ge;
    logic [DW:0] rem_new;

    // one restoring step
    assign rem_sh  = {rem_reg, quo_reg[NW-1]};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign rem_new = ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            quo_reg <= req.num;
            den_reg <= req.den;
            neg_reg <= req.neg;
        end else if (busy_reg) begin
            rem_reg <= rem_new[DW-1:0];
            quo_reg <= {quo_reg[NW-2:0], ge};
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = fsfe_pkg::sat_q(neg_reg, 64'(quo_reg));

endmodule

/* sim/fem_shape_function_eval_core_tb.sv */
// Testbench for fem_shape_function_eval_core: table writes and evaluations are
// checked against a predictor of the line-product shape functions. Needs fsfe_pkg.
`timescale 1ns / 1ps

module fem_shape_function_eval_core_tb;

    localparam int  N_SHAPES   = 8;
    localparam int  N_NODES    = 16;
    localparam int  N_LINES    = 8;
    localparam int  RUN_LIMIT  = 8000000;
    localparam int  HOLD_SPAN  = 4000;
    localparam int  DRAIN_WAIT = 400;
    localparam int  BIG_SHAPE  = 7;
    localparam longint ONE_Q   = 64'sd65536;
    localparam longint GRAD_SC = 64'sd268435456;

    typedef struct {
        logic [2:0]         cmd;
        logic [2:0]         shape;
        logic [3:0]         index;
        logic signed [15:0] node_x;
        logic signed [15:0] node_y;
        logic [3:0]         line_first;
        logic [3:0]         line_second;
        logic [7:0]         line_mask;
        logic [4:0]         node_total;
        logic [3:0]         line_total;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
    } shape_cmd_t;

    typedef struct packed {
        logic [3:0]         node;
        logic signed [31:0] value;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic               degen;
        logic               last;
    } shape_result_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [2:0]         s_cmd;
    logic [2:0]         s_shape_id;
    logic [3:0]         s_index;
    logic signed [15:0] s_node_x;
    logic signed [15:0] s_node_y;
    logic [3:0]         s_line_first;
    logic [3:0]         s_line_second;
    logic [7:0]         s_line_mask;
    logic [4:0]         s_node_total;
    logic [3:0]         s_line_total;
    logic signed [15:0] s_point_x;
    logic signed [15:0] s_point_y;
    logic               m_valid;
    logic               m_ready;
    logic [3:0]         m_node_number;
    logic signed [31:0] m_value;
    logic signed [31:0] m_deriv_x;
    logic signed [31:0] m_deriv_y;
    logic               m_degenerate;
    logic               m_last;

    fem_shape_function_eval_core DUT (.*);

    // Queues, idle control, error count
    shape_cmd_t    pending_cmds[$];
    shape_result_t expected_shapes[$];
    int            send_idle_pct;
    int            recv_stall_pct;
    logic          hold_req;
    logic          hold_off;
    int            hold_cnt;
    int            errors;
    int            cycles;

    // Predictor copy of the shape tables
    logic signed [15:0] tab_x[N_SHAPES][N_NODES];
    logic signed [15:0] tab_y[N_SHAPES][N_NODES];
    logic [7:0]         tab_mask[N_SHAPES][N_NODES];
    logic [3:0]         tab_la[N_SHAPES][N_LINES];
    logic [3:0]         tab_lb[N_SHAPES][N_LINES];
    int                 tab_nn[N_SHAPES];
    int                 tab_nl[N_SHAPES];

    // Generator-side tracking so evaluations never touch unwritten entries
    bit node_done[N_SHAPES][N_NODES];
    bit mask_done[N_SHAPES][N_NODES];
    bit line_done[N_SHAPES][N_LINES];
    int gen_nn[N_SHAPES];
    int gen_nl[N_SHAPES];

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Rounded division, ties away from zero
    function automatic longint div_round(input longint num, input longint den);
        bit                neg;
        longint unsigned   an;
        longint unsigned   ad;
        longint unsigned   q;
        neg = (num < 0) != (den < 0);
        an  = (num < 0) ? -num : num;
        ad  = (den < 0) ? -den : den;
        q   = (2 * an + ad) / (2 * ad);
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint q_mult(input longint a, input longint b);
        return sat32(div_round(a * b, ONE_Q));
    endfunction

    // Shape function value and gradient of every node, pushed as expectations
    function automatic void eval_shape(input shape_cmd_t c);
        int              sid;
        int              nn;
        int              nl;
        longint          f[N_LINES];
        longint          gx[N_LINES];
        longint          gy[N_LINES];
        longint          val, sdx, sdy, dp;
        longint          ax, ay, bx, by, ddx, ddy, d, num, nx, ny, px, py;
        bit              degen;
        logic [7:0]      mask;
        shape_result_t   r;
        sid = c.shape;
        nn  = tab_nn[sid];
        nl  = tab_nl[sid];
        px  = c.point_x;
        py  = c.point_y;
        for (int n = 0; n < nn; n++) begin
            mask  = tab_mask[sid][n];
            nx    = tab_x[sid][n];
            ny    = tab_y[sid][n];
            degen = 0;
            val   = ONE_Q;
            sdx   = 0;
            sdy   = 0;
            for (int l = 0; l < nl; l++) begin
                f[l] = 0;
                gx[l] = 0;
                gy[l] = 0;
                if (mask[l]) begin
                    ax  = tab_x[sid][tab_la[sid][l]];
                    ay  = tab_y[sid][tab_la[sid][l]];
                    bx  = tab_x[sid][tab_lb[sid][l]];
                    by  = tab_y[sid][tab_lb[sid][l]];
                    ddx = bx - ax;
                    ddy = by - ay;
                    d   = ddx * (ny - ay) - ddy * (nx - ax);
                    num = ddx * (py - ay) - ddy * (px - ax);
                    if (d == 0) begin
                        degen = 1;
                    end else begin
                        f[l]  = sat32(div_round(num * ONE_Q, d));
                        gx[l] = sat32(div_round(-ddy * GRAD_SC, d));
                        gy[l] = sat32(div_round(ddx * GRAD_SC, d));
                    end
                end
            end
            if (degen) begin
                val = 0;
            end else begin
                for (int l = 0; l < nl; l++) begin
                    if (mask[l]) begin
                        val = q_mult(val, f[l]);
                        dp  = ONE_Q;
                        for (int k = 0; k < nl; k++)
                            if (k != l && mask[k]) dp = q_mult(dp, f[k]);
                        sdx += q_mult(dp, gx[l]);
                        sdy += q_mult(dp, gy[l]);
                    end
                end
                sdx = sat32(sdx);
                sdy = sat32(sdy);
            end
            r.node  = n[3:0];
            r.value = val[31:0];
            r.dx    = sdx[31:0];
            r.dy    = sdy[31:0];
            r.degen = degen;
            r.last  = (n + 1 == nn);
            expected_shapes.push_back(r);
        end
    endfunction

    // Apply one accepted transaction to the predictor
    function automatic void track_shape_cmd(input shape_cmd_t c);
        case (c.cmd)
            fsfe_pkg::CMD_WR_NODE: begin
                tab_x[c.shape][c.index] = c.node_x;
                tab_y[c.shape][c.index] = c.node_y;
            end
            fsfe_pkg::CMD_WR_LINE: begin
                if (c.index < N_LINES) begin
                    tab_la[c.shape][c.index] = c.line_first;
                    tab_lb[c.shape][c.index] = c.line_second;
                end
            end
            fsfe_pkg::CMD_WR_MASK: tab_mask[c.shape][c.index] = c.line_mask;
            fsfe_pkg::CMD_WR_COUNT: begin
                tab_nn[c.shape] = (c.node_total > N_NODES) ? N_NODES : c.node_total;
                tab_nl[c.shape] = (c.line_total > N_LINES) ? N_LINES : c.line_total;
            end
            fsfe_pkg::CMD_EVAL: eval_shape(c);
            default: ;
        endcase
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic logic signed [15:0] rand_coord();
        if ($urandom_range(0, 1)) return 16'($urandom);
        return 16'(($urandom_range(0, 8) * 2048) - 8192);
    endfunction

    function automatic shape_cmd_t rand_fields();
        shape_cmd_t c;
        c.cmd         = fsfe_pkg::CMD_EVAL;
        c.shape       = 3'($urandom);
        c.index       = 4'($urandom);
        c.node_x      = 16'($urandom);
        c.node_y      = 16'($urandom);
        c.line_first  = 4'($urandom);
        c.line_second = 4'($urandom);
        c.line_mask   = 8'($urandom);
        c.node_total  = 5'($urandom);
        c.line_total  = 4'($urandom);
        c.point_x     = rand_coord();
        c.point_y     = rand_coord();
        return c;
    endfunction

    task automatic queue_cmd(input shape_cmd_t c);
        case (c.cmd)
            fsfe_pkg::CMD_WR_NODE:  node_done[c.shape][c.index] = 1;
            fsfe_pkg::CMD_WR_MASK:  mask_done[c.shape][c.index] = 1;
            fsfe_pkg::CMD_WR_LINE:  if (c.index < N_LINES) line_done[c.shape][c.index] = 1;
            fsfe_pkg::CMD_WR_COUNT: begin
                gen_nn[c.shape] = (c.node_total > N_NODES) ? N_NODES : c.node_total;
                gen_nl[c.shape] = (c.line_total > N_LINES) ? N_LINES : c.line_total;
            end
            default: ;
        endcase
        pending_cmds.push_back(c);
    endtask

    task automatic wr_node(input int sid, input int idx, input int x, input int y);
        shape_cmd_t c;
        c        = rand_fields();
        c.cmd    = fsfe_pkg::CMD_WR_NODE;
        c.shape  = 3'(sid);
        c.index  = 4'(idx);
        c.node_x = 16'(x);
        c.node_y = 16'(y);
        queue_cmd(c);
    endtask

    task automatic wr_line(input int sid, input int idx, input int a, input int b);
        shape_cmd_t c;
        c             = rand_fields();
        c.cmd         = fsfe_pkg::CMD_WR_LINE;
        c.shape       = 3'(sid);
        c.index       = 4'(idx);
        c.line_first  = 4'(a);
        c.line_second = 4'(b);
        queue_cmd(c);
    endtask

    task automatic wr_mask(input int sid, input int idx, input int m);
        shape_cmd_t c;
        c           = rand_fields();
        c.cmd       = fsfe_pkg::CMD_WR_MASK;
        c.shape     = 3'(sid);
        c.index     = 4'(idx);
        c.line_mask = 8'(m);
        queue_cmd(c);
    endtask

    task automatic wr_counts(input int sid, input int nn, input int nl);
        shape_cmd_t c;
        c            = rand_fields();
        c.cmd        = fsfe_pkg::CMD_WR_COUNT;
        c.shape      = 3'(sid);
        c.node_total = 5'(nn);
        c.line_total = 4'(nl);
        queue_cmd(c);
    endtask

    // Fill any table entry the evaluation may read, then evaluate
    task automatic evaluate(input int sid, input int x, input int y);
        shape_cmd_t c;
        for (int n = 0; n < N_NODES; n++)
            if (!node_done[sid][n]) wr_node(sid, n, rand_coord(), rand_coord());
        for (int n = 0; n < gen_nn[sid]; n++)
            if (!mask_done[sid][n]) wr_mask(sid, n, $urandom_range(0, 255));
        for (int l = 0; l < gen_nl[sid]; l++)
            if (!line_done[sid][l])
                wr_line(sid, l, $urandom_range(0, 15), $urandom_range(0, 15));
        c         = rand_fields();
        c.cmd     = fsfe_pkg::CMD_EVAL;
        c.shape   = 3'(sid);
        c.point_x = 16'(x);
        c.point_y = 16'(y);
        queue_cmd(c);
    endtask

    // One random transaction; the large shape is evaluated only rarely
    task automatic rand_step();
        shape_cmd_t c;
        int         pick;
        int         sid;
        pick = $urandom_range(0, 99);
        sid  = $urandom_range(0, BIG_SHAPE - 1);
        if (pick < 40) begin
            if ($urandom_range(0, 39) == 0) sid = BIG_SHAPE;
            evaluate(sid, rand_coord(), rand_coord());
        end else if (pick < 55) begin
            wr_node($urandom_range(0, 7), $urandom_range(0, 15), rand_coord(), rand_coord());
        end else if (pick < 70) begin
            wr_line($urandom_range(0, 7), $urandom_range(0, 15),
                    $urandom_range(0, 15), $urandom_range(0, 15));
        end else if (pick < 85) begin
            wr_mask($urandom_range(0, 7), $urandom_range(0, 15), $urandom_range(0, 255));
        end else if (pick < 95) begin
            if ($urandom_range(0, 3) == 0)
                wr_counts(BIG_SHAPE, $urandom_range(0, 31), $urandom_range(0, 15));
            else
                wr_counts(sid, $urandom_range(0, 5), $urandom_range(0, 4));
        end else begin
            c     = rand_fields();
            c.cmd = 3'(fsfe_pkg::CMD_EVAL) + 3'($urandom_range(1, 3));
            queue_cmd(c);
        end
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || s_valid || expected_shapes.size() != 0)
            @(posedge aclk);
    endtask

    // ---------------- driver ----------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                track_shape_cmd('{s_cmd, s_shape_id, s_index, s_node_x, s_node_y,
                                  s_line_first, s_line_second, s_line_mask,
                                  s_node_total, s_line_total, s_point_x, s_point_y});
            end
            if (!s_valid || s_ready) begin
                if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    shape_cmd_t c;
                    c = pending_cmds.pop_front();
                    s_valid       <= 1'b1;
                    s_cmd         <= c.cmd;
                    s_shape_id    <= c.shape;
                    s_index       <= c.index;
                    s_node_x      <= c.node_x;
                    s_node_y      <= c.node_y;
                    s_line_first  <= c.line_first;
                    s_line_second <= c.line_second;
                    s_line_mask   <= c.line_mask;
                    s_node_total  <= c.node_total;
                    s_line_total  <= c.line_total;
                    s_point_x     <= c.point_x;
                    s_point_y     <= c.point_y;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- long receiver hold-off ----------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_off <= 1'b0;
            hold_cnt <= 0;
        end else if (hold_req && !hold_off && hold_cnt == 0) begin
            hold_off <= 1'b1;
            hold_cnt <= HOLD_SPAN;
        end else if (hold_cnt > 1) begin
            hold_cnt <= hold_cnt - 1;
        end else if (hold_cnt == 1) begin
            hold_off <= 1'b0;
            hold_cnt <= -1;
        end
    end

    // ---------------- monitor ----------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                shape_result_t act;
                shape_result_t e;
                act = '{m_node_number, m_value, m_deriv_x, m_deriv_y, m_degenerate, m_last};
                if (expected_shapes.size() == 0) begin
                    errors++;
                    $display("%0t unexpected result: node %0d value %h dx %h dy %h deg %b last %b",
                             $time, act.node, act.value, act.dx, act.dy, act.degen, act.last);
                end else begin
                    e = expected_shapes.pop_front();
                    if (act !== e) begin
                        errors++;
                        $display("%0t mismatch expected: node %0d value %h dx %h dy %h deg %b last %b",
                                 $time, e.node, e.value, e.dx, e.dy, e.degen, e.last);
                        $display("%0t mismatch actual:   node %0d value %h dx %h dy %h deg %b last %b",
                                 $time, act.node, act.value, act.dx, act.dy, act.degen, act.last);
                    end
                end
            end
            m_ready <= hold_off ? 1'b0 : ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // ---------------- run limit ----------------
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("fem_shape_function_eval_core_tb failed");
            $finish;
        end
    end

    // ---------------- sequence ----------------
    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_cmd          = '0;
        s_shape_id     = '0;
        s_index        = '0;
        s_node_x       = '0;
        s_node_y       = '0;
        s_line_first   = '0;
        s_line_second  = '0;
        s_line_mask    = '0;
        s_node_total   = '0;
        s_line_total   = '0;
        s_point_x      = '0;
        s_point_y      = '0;
        m_ready        = 1'b0;
        hold_req       = 1'b0;
        errors         = 0;
        cycles         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int s = 0; s < N_SHAPES; s++) begin
            tab_nn[s] = 0;
            tab_nl[s] = 0;
            gen_nn[s] = 0;
            gen_nl[s] = 0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: zero node count gives nothing
        evaluate(2, 0, 0);
        // Bilinear unit quad on shape 0: each node takes the two opposite edges
        wr_node(0, 0, 0, 0);
        wr_node(0, 1, 4096, 0);
        wr_node(0, 2, 4096, 4096);
        wr_node(0, 3, 0, 4096);
        wr_line(0, 0, 0, 1);
        wr_line(0, 1, 1, 2);
        wr_line(0, 2, 2, 3);
        wr_line(0, 3, 3, 0);
        wr_line(0, 9, 1, 1);
        wr_mask(0, 0, 8'h06);
        wr_mask(0, 1, 8'h0c);
        wr_mask(0, 2, 8'h09);
        wr_mask(0, 3, 8'h03);
        wr_counts(0, 4, 4);
        evaluate(0, 2048, 2048);
        evaluate(0, -32768, 32767);
        evaluate(0, 32767, -32768);
        // Degenerate line (both ends one node), empty mask, mask bits above count
        wr_counts(1, 2, 2);
        wr_line(1, 0, 3, 3);
        wr_line(1, 1, 0, 5);
        wr_mask(1, 0, 8'h01);
        wr_mask(1, 1, 8'hfc);
        evaluate(1, 4096, -4096);
        // Saturated counts: every node, every line
        wr_counts(BIG_SHAPE, 31, 15);
        for (int n = 0; n < N_NODES; n++) wr_mask(BIG_SHAPE, n, 8'hff);
        evaluate(BIG_SHAPE, 32767, 32767);
        wr_counts(BIG_SHAPE, 3, 2);
        wait_drained();

        // Random phases with different idling
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 84 : (ph == 3) ? 19 : 0;
            recv_stall_pct = (ph == 2) ? 84 : (ph == 3) ? 19 : 0;
            for (int i = 0; i < 15; i++) rand_step();
            wait_drained();
        end

        // Long receiver hold-off with evaluations queued behind it
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b1;
        for (int i = 0; i < 12; i++) evaluate($urandom_range(0, 1), rand_coord(), rand_coord());
        wait_drained();

        repeat (DRAIN_WAIT) @(posedge aclk);
        if (expected_shapes.size() != 0) errors++;
        if (errors == 0)
            $display("fem_shape_function_eval_core_tb passed");
        else
            $display("fem_shape_function_eval_core_tb failed");
        $finish;
    end

endmodule

/* fem_shape_function_eval_core.f */
hw/rtl/fsfe_pkg.sv
hw/rtl/fsfe_ram.sv
hw/rtl/fsfe_div.sv
hw/rtl/fem_shape_function_eval_core.sv
sim/fem_shape_function_eval_core_tb.sv
